// ----- src/hmm_forward_scoring_macros.svh -----
// assertion macros for the hmm forward scoring block
// depends on nothing; included by files that assert
`ifndef HMM_FORWARD_SCORING_MACROS_SVH
`define HMM_FORWARD_SCORING_MACROS_SVH
`ifndef SYNTHESIS
`define HFS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HFS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFS_ASSERT(label, clk, rst, prop, msg)
`define HFS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- src/hfs_pkg.sv -----
// package for the hmm forward scoring block
// types and command codes; no dependencies
`default_nettype none
package hfs_pkg;
  localparam int CMD_W = 3;
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_W_INIT  = 3'd1;
  localparam logic [2:0] CMD_W_TRANS = 3'd2;
  localparam logic [2:0] CMD_W_EMIT  = 3'd3;
  localparam logic [2:0] CMD_OBSERVE = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  row_index;
    logic [3:0]  col_index;
    logic [15:0] prob_value;
    logic [3:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  state_index;
    logic [15:0] alpha_norm;
    logic [15:0] step_prob;
    logic        zero_sum;
    logic        last;
  } out_item_t;

  // control from sequencer to the cell row
  typedef struct packed {
    logic load;   // load normalized alpha values into cells
    logic shift;  // rotate alpha ring by one cell
    logic clear;  // zero accumulators
    logic mac;    // accumulate head alpha times trans
  } cell_ctl_t;
endpackage
`default_nettype wire

// ----- src/hfs_if.sv -----
// handshake channel interface for the hmm forward scoring block
// depends on nothing
`default_nettype none
interface hfs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/hfs_cell.sv -----
// one cell of the state row: holds an alpha and a transition accumulator
// depends on hfs_pkg
`default_nettype none
module hfs_cell #(
  parameter int PB = 16,
  parameter int AW = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hfs_pkg::cell_ctl_t   ctl,
  input  wire logic [PB-1:0]        alpha_in,
  input  wire logic [PB-1:0]        load_val,
  input  wire logic [PB-1:0]        head_alpha,
  input  wire logic [PB-1:0]        trans_val,
  output logic [PB-1:0]             alpha_out,
  output logic [AW-1:0]             acc
);
  import hfs_pkg::*;
  logic [2*PB-1:0] prod;
  assign prod = head_alpha * trans_val;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_out <= '0;
    end else if (ctl.load) begin
      alpha_out <= load_val;
    end else if (ctl.shift) begin
      alpha_out <= alpha_in;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.mac) begin
      acc <= acc + AW'(prod);
    end
  end
endmodule
`default_nettype wire

// ----- src/hfs_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module hfs_div #(
  parameter int NW = 32,
  parameter int DW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  assign trial = {rem[DW-1:0], n[NW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CW'(NW);
      end else if (busy) begin
        n <= {n[NW-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/hmm_forward_scoring.sv -----
// top level of the hmm forward scoring block
// depends on hfs_pkg, hfs_if, hfs_cell, hfs_div and the macro header
//
// usage: commands arrive on the in channel (hfs_if sink). load commands
// write the initial, transition and emission tables and produce no
// transfer; start rearms the first-step flag. observe computes a new
// alpha vector and gives NUM_STATES result transfers on the out channel,
// in state order, the final one marked by last.
// sequence: after the in transfer an observe runs a transition
// accumulation pass in the cell row (one alpha rotates past every cell each
// cycle; the first observation of a sequence runs the same pass), then
// forms raw values and the sum, then per state starts the divider, waits
// for the bit-serial division and presents the result on the out channel.
// the serial divider sets the rate. load and start complete in the idle
// state. in is not ready while an observe runs.
// reset clears the alpha vector and sets the first-step flag; the tables
// are undefined until written. a stalled receiver holds the result
// register and the sequencer waits on it.
`default_nettype none
`include "hmm_forward_scoring_macros.svh"
module hmm_forward_scoring #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 16,
  parameter int PROB_BITS   = 16
) (
  input wire logic clk,
  input wire logic rst,
  hfs_if.sink      in_ch,
  hfs_if.source    out_ch
);
  import hfs_pkg::*;
  localparam int N  = NUM_STATES;
  localparam int PB = PROB_BITS;
  localparam int SW = (N > 1) ? $clog2(N) : 1;
  localparam int EW = (N * NUM_SYMBOLS > 1) ? $clog2(N * NUM_SYMBOLS) : 1;
  localparam int AW = 2 * PB + SW + 1;
  localparam int UW = PB + SW + 1;
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_RAW, S_DIV, S_WAIT, S_OUT} st_t;
  st_t st;

  // tables; the transition table is kept per cell, one column each
  logic [PB-1:0] init_mem  [N];
  logic [PB-1:0] emit_mem  [N*NUM_SYMBOLS];

  in_item_t      cur;
  logic          first_step;
  logic          sym_ok;
  logic [SW-1:0] cnt;
  logic [SW-1:0] ocnt;
  logic [PB-1:0] raw  [N];
  logic [UW-1:0] sum;
  logic [PB-1:0] alpha_new [N];
  cell_ctl_t     ctl;
  logic [PB-1:0] alpha_o [N];
  logic [AW-1:0] acc [N];
  logic [PB-1:0] load_v [N];
  logic [PB-1:0] tv [N];
  logic [PB-1:0] pre;
  logic [PB-1:0] emit_v;
  logic [SW-1:0] eidx;
  logic [PB-1:0] emit_q;
  logic [2*PB-1:0] pe;
  logic [PB-1:0] raw_v;
  logic          dstart, ddone;
  logic [2*PB-1:0] dq;
  logic [PB-1:0] quo_sat;
  logic [PB-1:0] sum_sat;
  out_item_t     res;
  logic          res_v;
  logic          in_ok;
  logic          wr_row_ok;

  assign in_ok     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st == S_IDLE);
  assign wr_row_ok = 32'(in_ch.data.row_index) < N;

  // cell row: the ring rotates alpha; cell 0's output is the head
  generate
    for (genvar c = 0; c < N; c++) begin : g_cell
      // column c of the transition table: trans[j][c] for every source j
      logic [PB-1:0] tcol [N];
      always_ff @(posedge clk) begin
        if (in_ok && in_ch.data.command == CMD_W_TRANS && wr_row_ok &&
            32'(in_ch.data.col_index) == c) begin
          tcol[SW'(in_ch.data.row_index)] <= PB'(in_ch.data.prob_value);
        end
      end
      // head alpha index j = cnt, so cell i needs trans[cnt][i]
      assign tv[c]     = tcol[cnt];
      assign load_v[c] = alpha_new[c];
      hfs_cell #(.PB(PB), .AW(AW)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .alpha_in(alpha_o[(c + 1) % N]),
        .load_val(load_v[c]),
        .head_alpha(alpha_o[0]),
        .trans_val(tv[c]),
        .alpha_out(alpha_o[c]),
        .acc(acc[c])
      );
    end
  endgenerate

  // emission read one state ahead: state 0 during the mac pass, then cnt+1
  assign eidx = (st == S_RAW && cnt != SW'(N - 1)) ? cnt + 1'b1 : '0;

  always_ff @(posedge clk) begin
    emit_q <= emit_mem[EW'(32'(eidx) * NUM_SYMBOLS + 32'(cur.symbol))];
  end

  // per-state raw value during S_RAW, state cnt
  always_comb begin
    if (first_step) begin
      pre = init_mem[cnt];
    end else if ((acc[cnt] >> PB) > AW'(PMAX)) begin
      pre = PMAX;
    end else begin
      pre = PB'(acc[cnt] >> PB);
    end
    emit_v = sym_ok ? emit_q : '0;
    pe    = pre * emit_v;
    raw_v = PB'(pe >> PB);
  end

  assign quo_sat = (dq > (2*PB)'(PMAX)) ? PMAX : PB'(dq);
  assign sum_sat = (sum > UW'(PMAX)) ? PMAX : PB'(sum);

  hfs_div #(.NW(2*PB), .DW(UW)) u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num({raw[ocnt], {PB{1'b0}}}), .den(sum),
    .done(ddone), .quo(dq)
  );

  always_comb begin
    ctl       = '0;
    ctl.clear = (st == S_IDLE);
    ctl.mac   = (st == S_MAC);
    ctl.shift = (st == S_MAC);
    ctl.load  = (st == S_OUT) && res_v && out_ch.ready && (ocnt == SW'(N - 1));
  end

  assign out_ch.valid = res_v;
  assign out_ch.data  = res;

  always_ff @(posedge clk) begin
    // table writes
    if (in_ok) begin
      if (in_ch.data.command == CMD_W_INIT && wr_row_ok) begin
        init_mem[SW'(in_ch.data.row_index)] <= PB'(in_ch.data.prob_value);
      end
      if (in_ch.data.command == CMD_W_EMIT && wr_row_ok &&
          32'(in_ch.data.col_index) < NUM_SYMBOLS) begin
        emit_mem[EW'(32'(in_ch.data.row_index) * NUM_SYMBOLS +
                     32'(in_ch.data.col_index))] <= PB'(in_ch.data.prob_value);
      end
    end
    if (rst) begin
      st         <= S_IDLE;
      first_step <= 1'b1;
      res_v      <= 1'b0;
      dstart     <= 1'b0;
    end else begin
      dstart <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_ok) begin
            cur <= in_ch.data;
            sym_ok <= 32'(in_ch.data.symbol) < NUM_SYMBOLS;
            cnt <= '0;
            sum <= '0;
            if (in_ch.data.command == CMD_START) begin
              first_step <= 1'b1;
            end
            if (in_ch.data.command == CMD_OBSERVE) begin
              st <= S_MAC;
            end
          end
        end
        S_MAC: begin
          // each cycle the head alpha j=cnt meets trans[j][i] in cell i
          cnt <= (cnt == SW'(N - 1)) ? '0 : cnt + 1'b1;
          if (cnt == SW'(N - 1)) begin
            st <= S_RAW;
          end
        end
        S_RAW: begin
          raw[cnt] <= raw_v;
          sum      <= sum + UW'(raw_v);
          cnt      <= (cnt == SW'(N - 1)) ? '0 : cnt + 1'b1;
          if (cnt == SW'(N - 1)) begin
            st         <= S_DIV;
            ocnt       <= '0;
            dstart     <= 1'b1;
            first_step <= 1'b0;
          end
        end
        S_DIV: begin
          st <= S_WAIT;
        end
        S_WAIT: begin
          if (ddone) begin
            res.state_index     <= 3'(ocnt);
            res.alpha_norm      <= 16'((sum == '0) ? '0 : quo_sat);
            res.step_prob       <= 16'(sum_sat);
            res.zero_sum        <= (sum == '0);
            res.last            <= (ocnt == SW'(N - 1));
            alpha_new[ocnt]     <= (sum == '0) ? '0 : quo_sat;
            res_v               <= 1'b1;
            st                  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            res_v <= 1'b0;
            if (ocnt == SW'(N - 1)) begin
              st <= S_IDLE;
            end else begin
              ocnt   <= ocnt + 1'b1;
              dstart <= 1'b1;
              st     <= S_DIV;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `HFS_ASSERT(a_busy_not_ready, clk, rst, (st != S_IDLE) |-> !in_ch.ready, "ready while busy")
  `HFS_ASSERT(a_res_in_out, clk, rst, res_v |-> (st == S_OUT), "result outside out state")
  `HFS_ASSERT(a_zero_alpha, clk, rst, (res_v && res.zero_sum) |-> (res.alpha_norm == '0), "zero alpha")
  `HFS_ASSERT_NR(a_rst_first, clk, rst |=> first_step, "first step not set by reset")
endmodule
`default_nettype wire
